[src/cri_pkg.sv]
// shared types and constants for the color ramp interpolator
// no dependencies
package cri_pkg;

    localparam int MAX_STOPS_DEF     = 32;
    localparam int TABLE_ENTRIES_DEF = 256;

    localparam int POS_W  = 16;
    localparam int CHAN_W = 8;
    localparam int COL_W  = 3 * CHAN_W;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_FEW   = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             ins;      // insert shift/write this cycle
        logic [POS_W-1:0] pos;
        logic [COL_W-1:0] col;
    } t_cell_ctl;

endpackage

[src/cri_cell.sv]
// one stop cell: holds position and color, shifts up on insert
// depends on cri_pkg
module cri_cell (
    input  logic                    i_clk,
    input  logic                    i_occ,       // this slot holds a stop
    input  logic                    i_prev_occ,  // left neighbor holds a stop
    input  logic                    i_prev_gt,   // left neighbor position above new stop
    input  logic [cri_pkg::POS_W-1:0] i_prev_pos,
    input  logic [cri_pkg::COL_W-1:0] i_prev_col,
    input  logic                    i_is_tail,   // slot index equals stop count
    input  cri_pkg::t_cell_ctl      i_ctl,
    output logic                    o_gt,
    output logic [cri_pkg::POS_W-1:0] o_pos,
    output logic [cri_pkg::COL_W-1:0] o_col
);
    import cri_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [COL_W-1:0] r_col;
    logic             n_take_prev;
    logic             n_take_new;

    assign o_gt  = i_occ && (r_pos > i_ctl.pos);
    // new stop lands where left neighbor is not above it and this slot shifts or is tail
    assign n_take_prev = i_prev_occ && i_prev_gt;
    assign n_take_new  = !n_take_prev && (o_gt || i_is_tail);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (n_take_prev) begin
                r_pos <= i_prev_pos;
                r_col <= i_prev_col;
            end else if (n_take_new) begin
                r_pos <= i_ctl.pos;
                r_col <= i_ctl.col;
            end
        end
    end

    assign o_pos = r_pos;
    assign o_col = r_col;
endmodule

[src/cri_div.sv]
// restoring divider, one quotient bit per cycle
// depends on cri_pkg
module cri_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    import cri_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   n_rem;
    logic [DEN_W:0]   n_sub;

    assign n_rem = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign n_sub = n_rem - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!n_sub[DEN_W]) begin
                    r_rem <= n_sub;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_quo;
endmodule

[src/color_ramp_interpolator_unit.sv]
// color ramp interpolator top: stop cell chain, sequencer, divider
// depends on cri_pkg, cri_cell, cri_div
//
//  channel | handshake            | payload
//  input   | i_valid / o_ready    | i_action, i_stop_*, i_table_index
//  output  | o_valid / i_ready    | o_out_red, o_out_green, o_out_blue, o_status
//
// clear, a dropped insert, the unused code and a lookup on under two stops answer
// in the cycle after acceptance; an insert passes through S_INS, shifting all
// larger stops one cell up; a lookup finds x in S_X, scans 1 to MAX_STOPS - 1
// segments in S_SCAN, picks the segment in S_SEG, then runs three divisions in one
// shared divider (S_MUL, S_DIV per channel) and loads the result in S_OUT
// reset empties the table at once; o_ready stays low until the result is taken
module color_ramp_interpolator_unit
    import cri_pkg::*;
#(
    parameter int MAX_STOPS     = MAX_STOPS_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_action,
    input  logic [POS_W-1:0]       i_stop_position,
    input  logic [CHAN_W-1:0]      i_stop_red,
    input  logic [CHAN_W-1:0]      i_stop_green,
    input  logic [CHAN_W-1:0]      i_stop_blue,
    input  logic [7:0]             i_table_index,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [CHAN_W-1:0]      o_out_red,
    output logic [CHAN_W-1:0]      o_out_green,
    output logic [CHAN_W-1:0]      o_out_blue,
    output logic [1:0]             o_status
);
    localparam int D       = TABLE_ENTRIES - 1;
    localparam int D_W     = $clog2(TABLE_ENTRIES);
    localparam int IDX_W   = 8;
    localparam int CNT_W   = $clog2(MAX_STOPS + 1);
    localparam int SI_W    = $clog2(MAX_STOPS);
    localparam int X_W     = POS_W + D_W + 1;
    localparam int DEN_W   = POS_W + D_W + 1;
    localparam int NUM_W   = DEN_W + CHAN_W + 2;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_INS  = 8'b0000_0010,
        S_X    = 8'b0000_0100,
        S_SCAN = 8'b0000_1000,
        S_SEG  = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [CNT_W-1:0] r_count;
    logic [1:0]       r_act;
    logic [POS_W-1:0] r_pos;
    logic [COL_W-1:0] r_col;
    logic [IDX_W-1:0] r_idx;
    logic [X_W-1:0]   r_x;
    logic [SI_W-1:0]  r_k;
    logic [1:0]       r_ch;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_dx;
    logic [CHAN_W-1:0] r_res [3];

    t_cell_ctl        w_ctl;
    logic [POS_W-1:0] w_pos [MAX_STOPS];
    logic [COL_W-1:0] w_col [MAX_STOPS];
    logic [MAX_STOPS-1:0] w_gt;

    assign w_ctl.ins = (r_state == S_INS);
    assign w_ctl.pos = r_pos;
    assign w_ctl.col = r_col;

    for (genvar j = 0; j < MAX_STOPS; j++) begin : g_cell
        logic w_occ, w_pocc, w_pgt, w_tail;
        logic [POS_W-1:0] w_ppos;
        logic [COL_W-1:0] w_pcol;
        assign w_occ  = (CNT_W'(j) < r_count);
        assign w_tail = (CNT_W'(j) == r_count);
        if (j == 0) begin : g_first
            assign w_pocc = 1'b0;
            assign w_pgt  = 1'b0;
            assign w_ppos = '0;
            assign w_pcol = '0;
        end else begin : g_rest
            assign w_pocc = (CNT_W'(j - 1) < r_count);
            assign w_pgt  = w_gt[j-1];
            assign w_ppos = w_pos[j-1];
            assign w_pcol = w_col[j-1];
        end
        cri_cell u_cell (
            .i_clk(i_clk), .i_occ(w_occ), .i_prev_occ(w_pocc), .i_prev_gt(w_pgt),
            .i_prev_pos(w_ppos), .i_prev_col(w_pcol), .i_is_tail(w_tail),
            .i_ctl(w_ctl), .o_gt(w_gt[j]), .o_pos(w_pos[j]), .o_col(w_col[j])
        );
    end

    // segment stops read through the running scan index
    logic [POS_W-1:0] w_p0, w_p1, w_first, w_last;
    logic [COL_W-1:0] w_c0, w_c1;
    logic [SI_W-1:0]  w_k1, w_lastk;
    assign w_k1    = r_k + 1'b1;
    assign w_lastk = SI_W'(r_count - 1'b1);
    assign w_p0    = w_pos[r_k];
    assign w_p1    = w_pos[w_k1];
    assign w_c0    = w_col[r_k];
    assign w_c1    = w_col[w_k1];
    assign w_first = w_pos[0];
    assign w_last  = w_pos[w_lastk];

    logic [X_W-1:0] w_p1d, w_p0d;
    assign w_p1d = X_W'(w_p1) * X_W'(D);
    assign w_p0d = X_W'(w_p0) * X_W'(D);

    logic [CHAN_W-1:0] w_a, w_b;
    always_comb begin
        case (r_ch)
            2'd0:    begin w_a = w_c0[23:16]; w_b = w_c1[23:16]; end
            2'd1:    begin w_a = w_c0[15:8];  w_b = w_c1[15:8];  end
            default: begin w_a = w_c0[7:0];   w_b = w_c1[7:0];   end
        endcase
    end

    // numerator 2*(a*(den-dx) + b*dx) + den for the channel being divided
    logic [NUM_W-1:0] w_num;
    assign w_num = ((NUM_W'(w_a) * NUM_W'(r_den - r_dx)
                   + NUM_W'(w_b) * NUM_W'(r_dx)) << 1) + NUM_W'(r_den);

    logic             w_dstart, w_ddone;
    logic [NUM_W-1:0] w_quo;
    assign w_dstart = (r_state == S_MUL);
    cri_div #(.NUM_W(NUM_W), .DEN_W(DEN_W + 1)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_num), .i_den({r_den, 1'b0}), .o_done(w_ddone), .o_quo(w_quo)
    );

    logic [IDX_W-1:0] w_idx_sat;
    assign w_idx_sat = (32'(i_table_index) > D) ? IDX_W'(D) : i_table_index;

    assign o_ready = (r_state == S_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_act <= i_action;
                        r_pos <= i_stop_position;
                        r_col <= {i_stop_red, i_stop_green, i_stop_blue};
                        r_idx <= w_idx_sat;
                        o_out_red <= '0; o_out_green <= '0; o_out_blue <= '0;
                        o_status  <= ST_OK;
                        case (t_action'(i_action))
                            ACT_CLEAR: begin
                                r_count <= '0;
                                o_valid <= 1'b1;
                            end
                            ACT_INSERT: begin
                                if (r_count >= CNT_W'(MAX_STOPS)) begin
                                    o_status <= ST_FULL;
                                    o_valid  <= 1'b1;
                                end else
                                    r_state <= S_INS;
                            end
                            ACT_LOOKUP: begin
                                if (r_count < CNT_W'(2)) begin
                                    o_status <= ST_FEW;
                                    o_valid  <= 1'b1;
                                end else
                                    r_state <= S_X;
                            end
                            default: o_valid <= 1'b1;
                        endcase
                    end
                end
                S_INS: begin
                    r_count <= r_count + 1'b1;
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_X: begin
                    r_x <= X_W'(w_first) * X_W'(D)
                         + X_W'(r_idx) * X_W'(w_last - w_first);
                    r_k <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // advance while the right stop lies below x and is not the last stop
                    if ((CNT_W'(r_k) + CNT_W'(2) < r_count) && (w_p1d < r_x))
                        r_k <= w_k1;
                    else
                        r_state <= S_SEG;
                end
                S_SEG: begin
                    if (w_p1 == w_p0) begin
                        o_status <= ST_ZERO;
                        o_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_den <= DEN_W'(w_p1d - w_p0d);
                        r_dx  <= ((r_x - w_p0d) > (w_p1d - w_p0d))
                               ? DEN_W'(w_p1d - w_p0d) : DEN_W'(r_x - w_p0d);
                        r_ch  <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: begin
                    if (w_ddone) begin
                        r_res[r_ch] <= (w_quo > NUM_W'(255)) ? 8'hFF : w_quo[CHAN_W-1:0];
                        if (r_ch == 2'd2)
                            r_state <= S_OUT;
                        else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    o_out_red   <= r_res[0];
                    o_out_green <= r_res[1];
                    o_out_blue  <= r_res[2];
                    o_valid     <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[test/tb.sv]
// testbench for color_ramp_interpolator_unit: directed and random words, scoreboard check
// depends on cri_pkg and the color_ramp_interpolator_unit rtl
module tb;
    import cri_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTOPS = MAX_STOPS_DEF;
    localparam int NENT   = TABLE_ENTRIES_DEF;
    localparam int LIMIT  = 2000000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] status;
    } t_color_res;

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic [1:0] i_action;
    logic [15:0] i_stop_position;
    logic [7:0] i_stop_red, i_stop_green, i_stop_blue, i_table_index;
    logic [7:0] o_out_red, o_out_green, o_out_blue;
    logic [1:0] o_status;

    color_ramp_interpolator_unit dut (.*);

    // predictor state
    logic [15:0] ramp_pos [NSTOPS];
    logic [23:0] ramp_col [NSTOPS];
    int ramp_count;
    t_color_res color_queue[$];
    int mismatches, results_seen, lookups_sent, cycles;
    int burst_left;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] mix_chan(longint c0, longint c1, longint dx, longint den);
        longint v;
        v = (2 * (c0 * (den - dx) + c1 * dx) + den) / (2 * den);
        return v > 255 ? 8'd255 : v[7:0];
    endfunction

    function automatic t_color_res predict_color(t_action act, logic [15:0] pos,
                                                 logic [23:0] col, logic [7:0] idx);
        t_color_res res;
        longint d, first, x, p0, p1, den, dx, ix;
        int k;
        res = '0;
        case (act)
            ACT_CLEAR: ramp_count = 0;
            ACT_INSERT: begin
                if (ramp_count >= NSTOPS) begin
                    res.status = ST_FULL;
                end else begin
                    k = ramp_count;
                    while (k > 0 && ramp_pos[k-1] > pos) begin
                        ramp_pos[k] = ramp_pos[k-1];
                        ramp_col[k] = ramp_col[k-1];
                        k--;
                    end
                    ramp_pos[k] = pos;
                    ramp_col[k] = col;
                    ramp_count++;
                end
            end
            ACT_LOOKUP: begin
                if (ramp_count < 2) begin
                    res.status = ST_FEW;
                end else begin
                    d = NENT - 1;
                    ix = idx > d ? d : idx;
                    first = ramp_pos[0];
                    x = first * d + ix * (ramp_pos[ramp_count-1] - first);
                    k = 0;
                    while (k + 2 < ramp_count && ramp_pos[k+1] * d < x) k++;
                    p0 = ramp_pos[k];
                    p1 = ramp_pos[k+1];
                    if (p0 == p1) begin
                        res.status = ST_ZERO;
                    end else begin
                        den = (p1 - p0) * d;
                        dx = x - p0 * d;
                        if (dx > den) dx = den;
                        res.red   = mix_chan(ramp_col[k][23:16], ramp_col[k+1][23:16], dx, den);
                        res.green = mix_chan(ramp_col[k][15:8], ramp_col[k+1][15:8], dx, den);
                        res.blue  = mix_chan(ramp_col[k][7:0], ramp_col[k+1][7:0], dx, den);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // sends one word in bursts with random gaps
    task automatic send_word(t_action act, logic [15:0] pos, logic [23:0] col, logic [7:0] idx);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid = 1;
        i_action = act;
        i_stop_position = pos;
        {i_stop_red, i_stop_green, i_stop_blue} = col;
        i_table_index = idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        color_queue.insert(color_queue.size(), predict_color(act, pos, col, idx));
        if (act == ACT_LOOKUP) lookups_sent++;
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic drain_results();
        while (color_queue.size() != 0) @(negedge i_clk);
    endtask

    task automatic insert_rand(logic [15:0] pos);
        send_word(ACT_INSERT, pos, 24'($urandom), 8'($urandom));
    endtask

    task automatic test_directed();
        send_word(ACT_LOOKUP, 0, 0, 0);                   // empty table
        send_word(ACT_NONE, 16'hffff, 24'hffffff, 8'hff);  // unused code
        send_word(ACT_INSERT, 16'd0, 24'h000000, 0);
        send_word(ACT_LOOKUP, 0, 0, 8'd128);               // one stop
        send_word(ACT_INSERT, 16'hffff, 24'hffffff, 0);
        send_word(ACT_LOOKUP, 0, 0, 8'd0);
        send_word(ACT_LOOKUP, 0, 0, 8'd255);
        send_word(ACT_LOOKUP, 0, 0, 8'd127);
        send_word(ACT_INSERT, 16'h8000, 24'hff00ff, 0);
        send_word(ACT_INSERT, 16'h8000, 24'h00ff00, 0);    // equal position, zero-width
        send_word(ACT_LOOKUP, 0, 0, 8'd128);
        send_word(ACT_LOOKUP, 0, 0, 8'd200);
        send_word(ACT_CLEAR, 0, 0, 0);
        send_word(ACT_INSERT, 16'd77, 24'h123456, 0);
        send_word(ACT_INSERT, 16'd77, 24'habcdef, 0);      // all stops share one position
        send_word(ACT_LOOKUP, 0, 0, 8'd10);
        send_word(ACT_CLEAR, 0, 0, 0);
    endtask

    task automatic test_table_full();
        for (int n = 0; n < NSTOPS + 2; n++) insert_rand(16'($urandom));
        for (int n = 0; n < 6; n++) send_word(ACT_LOOKUP, 0, 0, 8'($urandom));
        send_word(ACT_CLEAR, 0, 0, 0);
    endtask

    task automatic test_random_ramps();
        int n, stops, r, base;
        n = 0;
        while (n < 400) begin
            stops = $urandom_range(0, 5) == 0 ? $urandom_range(0, NSTOPS + 1)
                                              : $urandom_range(2, 6);
            base = $urandom_range(0, 3) == 0 ? 16'hfff0 : 0;
            for (int s = 0; s < stops; s++) begin
                r = $urandom_range(0, 9);
                insert_rand(r == 0 ? 16'(base) : (r == 1 ? 16'h8000 : 16'($urandom)));
                n++;
            end
            for (int s = 0; s < $urandom_range(2, 10); s++) begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    send_word(ACT_NONE, 16'($urandom), 24'($urandom), 8'($urandom));
                else
                    send_word(ACT_LOOKUP, 16'($urandom), 24'($urandom), 8'($urandom));
                n++;
            end
            if ($urandom_range(0, 7) == 0) drain_results();   // sender holds off
            send_word(ACT_CLEAR, 16'($urandom), 24'($urandom), 8'($urandom));
            n++;
        end
    endtask

    // receiver stall pattern and result checker
    always @(negedge i_clk) begin
        if (cycles % 200 < 60) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        t_color_res exp_res, got;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_out_red, o_out_green, o_out_blue, o_status};
            results_seen++;
            if (color_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                exp_res = color_queue.pop_front();
                if (got !== exp_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp r%h g%h b%h s%0d got r%h g%h b%h s%0d",
                            exp_res.red, exp_res.green, exp_res.blue, exp_res.status,
                            o_out_red, o_out_green, o_out_blue, o_status);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("[color_ramp_interpolator_unit] ERROR");
            $finish;
        end
    end

    initial begin
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        lookups_sent = 0;
        burst_left = 0;
        ramp_count = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_action = ACT_CLEAR;
        i_stop_position = 0;
        {i_stop_red, i_stop_green, i_stop_blue} = 0;
        i_table_index = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;
        test_directed();
        test_table_full();
        test_random_ramps();
        drain_results();
        repeat (300) @(negedge i_clk);
        $display("covered %0d result words, %0d of them lookups, incl. full table and",
                 results_seen, lookups_sent);
        $display("zero-width segments, under-two-stop lookups and the unused action");
        if (mismatches == 0 && color_queue.size() == 0)
            $display("[color_ramp_interpolator_unit] OK");
        else
            $display("[color_ramp_interpolator_unit] ERROR");
        $finish;
    end
endmodule

[sim.f]
src/cri_pkg.sv
src/cri_cell.sv
src/cri_div.sv
src/color_ramp_interpolator_unit.sv
test/tb.sv
